### src/linear_blend_vertex_skinning_core_defines.svh
// Assertion macros shared by the skinning core.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_CORE_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LBVS_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("Next-cycle check failed.");
`define LBVS_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("Same-cycle check failed.");
`else
`define LBVS_ASSERT_NEXT(lbl, a, b)
`define LBVS_ASSERT_SAME(lbl, a, b)
`endif
`endif

### src/lbvs_pkg.sv
// Types, constants and arithmetic helpers of the skinning core.
package lbvs_pkg;
    localparam int WORDS_PER_BONE = 12;
    localparam int PACKED_SLOTS   = 4;
    localparam int ID_BITS        = 6;
    localparam int WEIGHT_BITS    = 16;
    localparam int WEIGHT_FRAC    = 15;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SKIN = 1'b1;

    typedef struct packed {
        logic               command;
        logic [23:0]        bone_ids;
        logic [63:0]        bone_weights;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [5:0]         load_bone;
        logic [3:0]         load_element;
        logic signed [31:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_nrm_x;
        logic signed [31:0] out_nrm_y;
        logic signed [31:0] out_nrm_z;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction
endpackage

### src/lbvs_in_if.sv
// Input channel of the skinning core: valid, ready and one input item.
interface lbvs_in_if
    import lbvs_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/lbvs_out_if.sv
// Output channel of the skinning core: valid, ready and one result item.
interface lbvs_out_if
    import lbvs_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/lbvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/linear_blend_vertex_skinning_core.sv
// Top level of the four-bone linear blend skinning core.
// A load transaction writes one palette word; a skin transaction returns one skinned
// position and normal. One transaction is accepted every cycle unless stalled: each
// of the four bone slots owns a copy of the palette, split into twelve word RAMs, so
// all 48 words of a vertex are read at once. Each stage holds its item only while the
// stage after it is full, so bubbles close up under output backpressure.
`include "linear_blend_vertex_skinning_core_defines.svh"
module linear_blend_vertex_skinning_core
    import lbvs_pkg::*;
#(
    parameter int NUM_BONES        = 64,
    parameter int BONES_PER_VERTEX = 4,
    parameter int FRAC_BITS        = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbvs_in_if.sink    i_in,
    lbvs_out_if.source o_out
);
    localparam int AW = NUM_BONES > 1 ? $clog2(NUM_BONES) : 1;
    localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic en1, en2, en3, en4, en5;
    logic accept;

    logic [31:0] w_rd [PACKED_SLOTS][WORDS_PER_BONE];
    logic [15:0] n_w [PACKED_SLOTS];
    logic [AW-1:0] w_raddr [PACKED_SLOTS];
    logic [7:0] ld_bone8;
    logic ld_ok;

    logic [15:0]        r1_w [PACKED_SLOTS];
    logic signed [31:0] r1_pos [3];
    logic signed [31:0] r1_nrm [3];
    logic signed [48:0] r2_prod [PACKED_SLOTS][WORDS_PER_BONE];
    logic signed [31:0] r2_pos [3];
    logic signed [31:0] r2_nrm [3];
    logic signed [31:0] r3_blend [WORDS_PER_BONE];
    logic signed [31:0] n_blend [WORDS_PER_BONE];
    logic signed [31:0] r3_pos [3];
    logic signed [31:0] r3_nrm [3];
    logic signed [63:0] r4_pp [3][3];
    logic signed [63:0] r4_np [3][3];
    logic signed [31:0] r4_trans [3];
    logic signed [31:0] n_opos [3];
    logic signed [31:0] n_onrm [3];
    t_out_item r_out;

    assign en5 = !r_ov || o_out.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;
    assign accept = i_in.valid && en1;

    assign ld_bone8 = {2'b00, i_in.data.load_bone};
    assign ld_ok = (9'({1'b0, ld_bone8}) < 9'(NUM_BONES))
                && (i_in.data.load_element < 4'(WORDS_PER_BONE));

    always_comb begin
        logic [7:0] id8;
        for (int s = 0; s < PACKED_SLOTS; s++) begin
            id8 = {2'b00, i_in.data.bone_ids[s*ID_BITS +: ID_BITS]};
            w_raddr[s] = id8[AW-1:0];
            if (s < BONES_PER_VERTEX && 9'({1'b0, id8}) < 9'(NUM_BONES)) begin
                n_w[s] = i_in.data.bone_weights[s*WEIGHT_BITS +: WEIGHT_BITS];
            end else begin
                n_w[s] = '0;
            end
        end
    end

    for (genvar s = 0; s < PACKED_SLOTS; s++) begin : g_slot
        for (genvar e = 0; e < WORDS_PER_BONE; e++) begin : g_word
            if (s < BONES_PER_VERTEX) begin : g_ram
                lbvs_ram #(.WIDTH(32), .DEPTH(NUM_BONES)) u_ram (
                    .i_clk   (i_clk),
                    .i_we    (accept && i_in.data.command == CMD_LOAD && ld_ok
                              && i_in.data.load_element == 4'(e)),
                    .i_waddr (ld_bone8[AW-1:0]),
                    .i_wdata (i_in.data.load_value),
                    .i_re    (en1),
                    .i_raddr (w_raddr[s]),
                    .o_rdata (w_rd[s][e])
                );
            end else begin : g_none
                assign w_rd[s][e] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept && i_in.data.command == CMD_SKIN;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_ov <= r_v4;
            end
        end
    end

    always_comb begin
        logic signed [50:0] acc;
        for (int e = 0; e < WORDS_PER_BONE; e++) begin
            acc = 51'sd16384;
            for (int s = 0; s < PACKED_SLOTS; s++) begin
                acc = acc + 51'(r2_prod[s][e]);
            end
            n_blend[e] = sat32(66'(acc >>> WEIGHT_FRAC));
        end
    end

    always_comb begin
        logic signed [65:0] sp;
        logic signed [65:0] sn;
        for (int i = 0; i < 3; i++) begin
            sp = RND;
            sn = RND;
            for (int j = 0; j < 3; j++) begin
                sp = sp + 66'(r4_pp[i][j]);
                sn = sn + 66'(r4_np[i][j]);
            end
            n_opos[i] = sat32((sp >>> FRAC_BITS) + 66'(r4_trans[i]));
            n_onrm[i] = sat32(sn >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_w   <= n_w;
            r1_pos <= '{i_in.data.pos_x, i_in.data.pos_y, i_in.data.pos_z};
            r1_nrm <= '{i_in.data.nrm_x, i_in.data.nrm_y, i_in.data.nrm_z};
        end
        if (en2) begin
            for (int s = 0; s < PACKED_SLOTS; s++) begin
                for (int e = 0; e < WORDS_PER_BONE; e++) begin
                    r2_prod[s][e] <= $signed(w_rd[s][e]) * $signed({1'b0, r1_w[s]});
                end
            end
            r2_pos <= r1_pos;
            r2_nrm <= r1_nrm;
        end
        if (en3) begin
            r3_blend <= n_blend;
            r3_pos   <= r2_pos;
            r3_nrm   <= r2_nrm;
        end
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_pp[i][j] <= r3_blend[i*4 + j] * r3_pos[j];
                    r4_np[i][j] <= r3_blend[i*4 + j] * r3_nrm[j];
                end
                r4_trans[i] <= r3_blend[i*4 + 3];
            end
        end
        if (en5) begin
            r_out.out_pos_x <= n_opos[0];
            r_out.out_pos_y <= n_opos[1];
            r_out.out_pos_z <= n_opos[2];
            r_out.out_nrm_x <= n_onrm[0];
            r_out.out_nrm_y <= n_onrm[1];
            r_out.out_nrm_z <= n_onrm[2];
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    `LBVS_ASSERT_NEXT(a_load_no_result, accept && i_in.data.command == CMD_LOAD, !r_v1)
    `LBVS_ASSERT_NEXT(a_skin_enters, accept && i_in.data.command == CMD_SKIN, r_v1)
    `LBVS_ASSERT_SAME(a_stall_full, !i_in.ready, r_v1 && r_v2 && r_v3 && r_v4 && r_ov)
    `LBVS_ASSERT_NEXT(a_stage4_holds, r_v4 && !en4, r_v4)
endmodule
